@@ design/psg_tone_noise_generator_assert.svh @@
`ifndef PSG_TONE_NOISE_GENERATOR_ASSERT_SVH
`define PSG_TONE_NOISE_GENERATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PSG_CHECK(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("psg check failed");

// Next-cycle implication, checked outside reset.
`define PSG_CHECK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("psg check failed");

`endif

@@ design/psg_pkg.sv @@
package psg_pkg;

  // Default sizing of the time base.
  localparam int PSG_MASTER_DIVIDE = 15;
  localparam int PSG_SAMPLE_DIVIDE = 16;
  localparam int PSG_MAX_TICK      = 63;

  // Fixed field widths.
  localparam int TICK_W   = 6;
  localparam int PERIOD_W = 10;
  localparam int VOL_W    = 4;
  localparam int LFSR_W   = 16;
  localparam int NUM_TONE = 3;

  // Opcodes of an input item.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // Channel code of the noise channel in a latch byte.
  localparam logic [1:0] CH_NOISE = 2'd3;

  // Noise rate codes and the fixed reload values of the first three.
  localparam logic [1:0] RATE_16 = 2'd0;
  localparam logic [1:0] RATE_32 = 2'd1;
  localparam logic [1:0] RATE_64 = 2'd2;
  localparam logic [1:0] RATE_T2 = 2'd3;
  localparam logic [PERIOD_W-1:0] RELOAD_16 = 10'h010;
  localparam logic [PERIOD_W-1:0] RELOAD_32 = 10'h020;
  localparam logic [PERIOD_W-1:0] RELOAD_64 = 10'h040;

  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'h8000;

  typedef struct packed {
    logic              opcode;
    logic [7:0]        write_byte;
    logic [TICK_W-1:0] master_cycles;
  } psg_in_t;

  typedef struct packed {
    logic             tone0_high;
    logic             tone1_high;
    logic             tone2_high;
    logic             noise_high;
    logic [VOL_W-1:0] tone0_level;
    logic [VOL_W-1:0] tone1_level;
    logic [VOL_W-1:0] tone2_level;
    logic [VOL_W-1:0] noise_level;
  } psg_out_t;

  // Classified item as it waits in the queue between front and back.
  typedef struct packed {
    logic              is_tick;
    logic [7:0]        wbyte;
    logic [TICK_W-1:0] cycles;
  } psg_cmd_t;

  // A period of zero is stored as one.
  function automatic logic [PERIOD_W-1:0] nonzero_period(input logic [PERIOD_W-1:0] p);
    nonzero_period = (p == '0) ? PERIOD_W'(1) : p;
  endfunction

endpackage

@@ design/psg_front.sv @@
module psg_front
  import psg_pkg::*;
#(
  parameter int MAX_TICK = PSG_MAX_TICK
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  psg_in_t  in_data,
  output logic     cmd_valid,
  input  logic     cmd_ready,
  output psg_cmd_t cmd_data
);

  // Two-entry queue; the depth is a power of two so pointers wrap freely.
  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  psg_cmd_t          queue_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  psg_cmd_t          cmd_in;
  logic              push, pop;

  // Classify the item and saturate the cycle count.
  always_comb begin
    cmd_in.is_tick = (in_data.opcode == OP_TICK);
    cmd_in.wbyte   = in_data.write_byte;
    if (32'(in_data.master_cycles) > MAX_TICK) begin
      cmd_in.cycles = TICK_W'(MAX_TICK);
    end else begin
      cmd_in.cycles = in_data.master_cycles;
    end
  end

  assign in_ready  = (count_r != CNT_W'(QUEUE_DEPTH));
  assign push      = in_valid && in_ready;
  assign cmd_valid = (count_r != '0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd_data  = queue_r[rd_ptr_r];

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

@@ design/psg_back.sv @@
module psg_back
  import psg_pkg::*;
#(
  parameter int MASTER_DIVIDE = PSG_MASTER_DIVIDE,
  parameter int SAMPLE_DIVIDE = PSG_SAMPLE_DIVIDE
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cmd_valid,
  output logic     cmd_ready,
  input  psg_cmd_t cmd_data,
  output logic     out_valid,
  input  logic     out_ready,
  output psg_out_t out_data
);

  localparam int MR_W  = (MASTER_DIVIDE > 1) ? $clog2(MASTER_DIVIDE) : 1;
  localparam int CR_W  = (SAMPLE_DIVIDE > 1) ? $clog2(SAMPLE_DIVIDE) : 1;
  localparam int ACC_W = $clog2(MASTER_DIVIDE + 64);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                state_r, state_nxt;
  logic [ACC_W-1:0]    acc_r, acc_nxt;
  logic [MR_W-1:0]     mrem_r, mrem_nxt;
  logic [CR_W-1:0]     crem_r, crem_nxt;
  logic                produced_r, produced_nxt;

  logic [PERIOD_W-1:0] period_r [NUM_TONE];
  logic [PERIOD_W-1:0] period_nxt [NUM_TONE];
  logic [PERIOD_W-1:0] tcount_r [NUM_TONE];
  logic [PERIOD_W-1:0] tcount_nxt [NUM_TONE];
  logic [NUM_TONE-1:0] pol_r, pol_nxt;
  logic [VOL_W-1:0]    vol_r [NUM_TONE];
  logic [VOL_W-1:0]    vol_nxt [NUM_TONE];
  logic [PERIOD_W-1:0] ncount_r, ncount_nxt;
  logic [PERIOD_W-1:0] nreload_r, nreload_nxt;
  logic [3:0]          nmode_r, nmode_nxt;
  logic [VOL_W-1:0]    nvol_r, nvol_nxt;
  logic [LFSR_W-1:0]   lfsr_r, lfsr_nxt;
  logic                nbit_r, nbit_nxt;
  logic [1:0]          latch_ch_r, latch_ch_nxt;
  logic                latch_vol_r, latch_vol_nxt;

  logic                out_valid_r, out_valid_nxt;
  psg_out_t            out_data_r, out_data_nxt;

  assign cmd_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Command execution: byte writes; ticks one chip clock per cycle unless stalled.
  always_comb begin
    logic       take;
    logic [7:0] b;
    logic       step;
    logic       boundary;
    logic       out_free;
    logic       fb;

    take     = cmd_valid && (state_r == ST_IDLE);
    b        = cmd_data.wbyte;
    out_free = !out_valid_r || out_ready;
    step     = 1'b0;
    boundary = 1'b0;
    fb       = 1'b0;

    state_nxt     = state_r;
    acc_nxt       = acc_r;
    mrem_nxt      = mrem_r;
    crem_nxt      = crem_r;
    produced_nxt  = produced_r;
    period_nxt    = period_r;
    tcount_nxt    = tcount_r;
    pol_nxt       = pol_r;
    vol_nxt       = vol_r;
    ncount_nxt    = ncount_r;
    nreload_nxt   = nreload_r;
    nmode_nxt     = nmode_r;
    nvol_nxt      = nvol_r;
    lfsr_nxt      = lfsr_r;
    nbit_nxt      = nbit_r;
    latch_ch_nxt  = latch_ch_r;
    latch_vol_nxt = latch_vol_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      ST_IDLE: begin
        if (take && cmd_data.is_tick) begin
          acc_nxt      = ACC_W'(mrem_r) + ACC_W'(cmd_data.cycles);
          produced_nxt = 1'b0;
          state_nxt    = ST_RUN;
        end else if (take && b[7]) begin
          // Latch byte: channel, kind and four data bits.
          latch_ch_nxt  = b[6:5];
          latch_vol_nxt = b[4];
          if (b[6:5] != CH_NOISE) begin
            for (int i = 0; i < NUM_TONE; i++) begin
              if (b[6:5] == 2'(i)) begin
                if (b[4]) begin
                  vol_nxt[i] = b[3:0];
                end else begin
                  period_nxt[i] = nonzero_period({period_r[i][PERIOD_W-1:4], b[3:0]});
                end
              end
            end
          end else if (b[4]) begin
            nvol_nxt = b[3:0];
          end else begin
            nmode_nxt = b[3:0];
            unique case (b[1:0])
              RATE_16: nreload_nxt = RELOAD_16;
              RATE_32: nreload_nxt = RELOAD_32;
              RATE_64: nreload_nxt = RELOAD_64;
              RATE_T2: nreload_nxt = period_r[2];
            endcase
          end
        end else if (take) begin
          // Data byte: upper period bits of the latched tone channel.
          if (latch_ch_r != CH_NOISE && !latch_vol_r) begin
            for (int i = 0; i < NUM_TONE; i++) begin
              if (latch_ch_r == 2'(i)) begin
                period_nxt[i] = nonzero_period({b[5:0], period_r[i][3:0]});
              end
            end
          end
        end
      end
      ST_RUN: begin
        if (acc_r >= ACC_W'(MASTER_DIVIDE)) begin
          boundary = (crem_r == CR_W'(SAMPLE_DIVIDE - 1)) && !produced_r;
          // Hold the chip clock that ends a sample period until the result slot frees.
          step = !boundary || out_free;
        end else begin
          mrem_nxt  = acc_r[MR_W-1:0];
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // One chip clock.
    if (step) begin
      acc_nxt = acc_r - ACC_W'(MASTER_DIVIDE);
      if (crem_r == CR_W'(SAMPLE_DIVIDE - 1)) begin
        crem_nxt = '0;
      end else begin
        crem_nxt = crem_r + CR_W'(1);
      end
      for (int i = 0; i < NUM_TONE; i++) begin
        if (tcount_r[i] == '0) begin
          tcount_nxt[i] = period_r[i];
          pol_nxt[i]    = !pol_r[i];
        end else begin
          tcount_nxt[i] = tcount_r[i] - PERIOD_W'(1);
        end
      end
      if (ncount_r == '0) begin
        ncount_nxt = nreload_r;
        fb         = nmode_r[2] ? (lfsr_r[0] ^ lfsr_r[1]) : lfsr_r[0];
        lfsr_nxt   = {fb, lfsr_r[LFSR_W-1:1]};
        nbit_nxt   = lfsr_r[1];
      end else begin
        ncount_nxt = ncount_r - PERIOD_W'(1);
      end
      if (boundary) begin
        produced_nxt               = 1'b1;
        out_valid_nxt              = 1'b1;
        out_data_nxt.tone0_high    = pol_nxt[0];
        out_data_nxt.tone1_high    = pol_nxt[1];
        out_data_nxt.tone2_high    = pol_nxt[2];
        out_data_nxt.noise_high    = nbit_nxt;
        out_data_nxt.tone0_level   = vol_r[0];
        out_data_nxt.tone1_level   = vol_r[1];
        out_data_nxt.tone2_level   = vol_r[2];
        out_data_nxt.noise_level   = nvol_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      acc_r       <= '0;
      mrem_r      <= '0;
      crem_r      <= '0;
      produced_r  <= 1'b0;
      for (int i = 0; i < NUM_TONE; i++) begin
        period_r[i] <= '0;
        tcount_r[i] <= '0;
        vol_r[i]    <= '0;
      end
      pol_r       <= '0;
      ncount_r    <= '0;
      nreload_r   <= '0;
      nmode_r     <= '0;
      nvol_r      <= '0;
      lfsr_r      <= LFSR_SEED;
      nbit_r      <= 1'b0;
      latch_ch_r  <= '0;
      latch_vol_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      mrem_r      <= mrem_nxt;
      crem_r      <= crem_nxt;
      produced_r  <= produced_nxt;
      period_r    <= period_nxt;
      tcount_r    <= tcount_nxt;
      vol_r       <= vol_nxt;
      pol_r       <= pol_nxt;
      ncount_r    <= ncount_nxt;
      nreload_r   <= nreload_nxt;
      nmode_r     <= nmode_nxt;
      nvol_r      <= nvol_nxt;
      lfsr_r      <= lfsr_nxt;
      nbit_r      <= nbit_nxt;
      latch_ch_r  <= latch_ch_nxt;
      latch_vol_r <= latch_vol_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule

@@ design/psg_tone_noise_generator.sv @@
// Channel  Direction  Handshake                Payload
// in       input      in_valid / in_ready      in_data   (psg_in_t)
// out      output     out_valid / out_ready    out_data  (psg_out_t)
//
// The execution unit takes a byte write from the queue while it is idle.
// A tick is loaded, runs one chip clock per cycle while the result side allows, and
// finishes, carrying the master cycle remainder on to the next tick.
// The chip clock that ends a sample period waits while the result register is full.
// A two-entry queue lets items arrive while a tick runs.
// Reset is synchronous; queue storage and the result payload are not reset.
module psg_tone_noise_generator
  import psg_pkg::*;
#(
  parameter int MASTER_DIVIDE = PSG_MASTER_DIVIDE,
  parameter int SAMPLE_DIVIDE = PSG_SAMPLE_DIVIDE,
  parameter int MAX_TICK      = PSG_MAX_TICK
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  psg_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output psg_out_t out_data
);

  logic     cmd_valid;
  logic     cmd_ready;
  psg_cmd_t cmd_data;

  // Front: accept, classify and queue items.
  psg_front #(
    .MAX_TICK(MAX_TICK)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd_data (cmd_data)
  );

  // Back: register writes, chip clocks and the result register.
  psg_back #(
    .MASTER_DIVIDE(MASTER_DIVIDE),
    .SAMPLE_DIVIDE(SAMPLE_DIVIDE)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd_data (cmd_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

@@ design/psg_checker.sv @@
`include "psg_tone_noise_generator_assert.svh"

module psg_checker
  import psg_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input psg_in_t  in_data,
  input logic     out_valid,
  input logic     out_ready,
  input psg_out_t out_data
);

  // A stalled result keeps its value.
  `PSG_CHECK_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // The result register is empty right after reset.
  `PSG_CHECK(a_out_clear_after_reset, $past(!rst_n), !out_valid)

  // The queue is empty, so an item can enter, right after reset.
  `PSG_CHECK(a_ready_after_reset, $past(!rst_n), in_ready)

  // The queue only fills up through an accepted item.
  `PSG_CHECK(a_ready_drop_on_accept, $fell(in_ready), $past(in_valid))

endmodule

bind psg_tone_noise_generator psg_checker u_psg_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

@@ tb/psg_sample_checker.sv @@
// Watches both channels of the tone/noise generator, keeps its own copy of the
// chip state and compares every accepted result with the oldest predicted one.
module psg_sample_checker
  import psg_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_ready,
  input  psg_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_ready,
  input  psg_out_t out_data,
  output int       error_count,
  output int       samples_due
);

  // Bit positions inside a register byte and the noise control nibble.
  localparam int LATCH_BIT = 7;
  localparam int KIND_BIT  = 4;
  localparam int WHITE_BIT = 2;

  // Mirrored chip state.
  logic [PERIOD_W-1:0] tone_period_m [NUM_TONE];
  logic [PERIOD_W-1:0] tone_count_m  [NUM_TONE];
  logic                tone_pol_m    [NUM_TONE];
  logic [VOL_W-1:0]    tone_vol_m    [NUM_TONE];
  logic [PERIOD_W-1:0] noise_count_m;
  logic [PERIOD_W-1:0] noise_reload_m;
  logic [3:0]          noise_ctrl_m;
  logic [VOL_W-1:0]    noise_vol_m;
  logic [LFSR_W-1:0]   lfsr_m;
  logic                noise_out_m;
  logic [1:0]          latch_ch_m;
  logic                latch_vol_m;
  int                  master_left;
  int                  chip_left;

  // Samples predicted but not yet seen on the result channel.
  psg_out_t expected_samples[$];

  initial begin
    error_count = 0;
    samples_due = 0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH at %0t: %s is %0h, expected %0h", $time, what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin : track
    psg_out_t            want;
    logic [PERIOD_W-1:0] p;
    logic [3:0]          nib;
    logic                fb;
    int                  cycles;
    bit                  produced;
    if (!rst_n) begin
      for (int i = 0; i < NUM_TONE; i++) begin
        tone_period_m[i] = '0;
        tone_count_m[i]  = '0;
        tone_pol_m[i]    = 1'b0;
        tone_vol_m[i]    = '0;
      end
      noise_count_m  = '0;
      noise_reload_m = '0;
      noise_ctrl_m   = '0;
      noise_vol_m    = '0;
      lfsr_m         = LFSR_SEED;
      noise_out_m    = 1'b0;
      latch_ch_m     = '0;
      latch_vol_m    = 1'b0;
      master_left    = 0;
      chip_left      = 0;
      expected_samples.delete();
    end else begin
      // Predict the effect of an accepted input item.
      if (in_valid && in_ready) begin
        if (in_data.opcode == OP_WRITE) begin
          nib = in_data.write_byte[3:0];
          if (in_data.write_byte[LATCH_BIT]) begin
            latch_ch_m  = in_data.write_byte[6:5];
            latch_vol_m = in_data.write_byte[KIND_BIT];
            if (latch_ch_m != CH_NOISE) begin
              if (latch_vol_m) begin
                tone_vol_m[latch_ch_m] = nib;
              end else begin
                p = {tone_period_m[latch_ch_m][9:4], nib};
                tone_period_m[latch_ch_m] = (p == '0) ? PERIOD_W'(1) : p;
              end
            end else if (latch_vol_m) begin
              noise_vol_m = nib;
            end else begin
              // The rate taken from tone 2 is a snapshot of its period now.
              noise_ctrl_m = nib;
              case (nib[1:0])
                RATE_16: noise_reload_m = RELOAD_16;
                RATE_32: noise_reload_m = RELOAD_32;
                RATE_64: noise_reload_m = RELOAD_64;
                default: noise_reload_m = tone_period_m[2];
              endcase
            end
          end else if (latch_ch_m != CH_NOISE && !latch_vol_m) begin
            // A data byte fills the upper period bits; after a volume or
            // noise latch it has no effect.
            p = {in_data.write_byte[5:0], tone_period_m[latch_ch_m][3:0]};
            tone_period_m[latch_ch_m] = (p == '0) ? PERIOD_W'(1) : p;
          end
        end else begin
          cycles = int'(in_data.master_cycles);
          if (cycles > PSG_MAX_TICK) cycles = PSG_MAX_TICK;
          master_left += cycles;
          produced = 1'b0;
          while (master_left >= PSG_MASTER_DIVIDE) begin
            master_left -= PSG_MASTER_DIVIDE;
            chip_left++;
            for (int i = 0; i < NUM_TONE; i++) begin
              if (tone_count_m[i] == '0) begin
                tone_count_m[i] = tone_period_m[i];
                tone_pol_m[i]   = ~tone_pol_m[i];
              end else begin
                tone_count_m[i] = tone_count_m[i] - PERIOD_W'(1);
              end
            end
            if (noise_count_m == '0) begin
              noise_count_m = noise_reload_m;
              fb = noise_ctrl_m[WHITE_BIT] ? (lfsr_m[0] ^ lfsr_m[1]) : lfsr_m[0];
              lfsr_m      = {fb, lfsr_m[LFSR_W-1:1]};
              noise_out_m = lfsr_m[0];
            end else begin
              noise_count_m = noise_count_m - PERIOD_W'(1);
            end
            // Only the first sample boundary of an item is reported.
            if (chip_left >= PSG_SAMPLE_DIVIDE) begin
              chip_left -= PSG_SAMPLE_DIVIDE;
              if (!produced) begin
                want.tone0_high  = tone_pol_m[0];
                want.tone1_high  = tone_pol_m[1];
                want.tone2_high  = tone_pol_m[2];
                want.noise_high  = noise_out_m;
                want.tone0_level = tone_vol_m[0];
                want.tone1_level = tone_vol_m[1];
                want.tone2_level = tone_vol_m[2];
                want.noise_level = noise_vol_m;
                expected_samples.push_back(want);
                produced = 1'b1;
              end
            end
          end
        end
      end

      // Compare an accepted result with the oldest prediction.
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          report_mismatch("unexpected result", 32'(out_data), '0);
        end else begin
          want = expected_samples.pop_front();
          if (out_data.tone0_high !== want.tone0_high)
            report_mismatch("tone0_high", 32'(out_data.tone0_high), 32'(want.tone0_high));
          if (out_data.tone1_high !== want.tone1_high)
            report_mismatch("tone1_high", 32'(out_data.tone1_high), 32'(want.tone1_high));
          if (out_data.tone2_high !== want.tone2_high)
            report_mismatch("tone2_high", 32'(out_data.tone2_high), 32'(want.tone2_high));
          if (out_data.noise_high !== want.noise_high)
            report_mismatch("noise_high", 32'(out_data.noise_high), 32'(want.noise_high));
          if (out_data.tone0_level !== want.tone0_level)
            report_mismatch("tone0_level", 32'(out_data.tone0_level), 32'(want.tone0_level));
          if (out_data.tone1_level !== want.tone1_level)
            report_mismatch("tone1_level", 32'(out_data.tone1_level), 32'(want.tone1_level));
          if (out_data.tone2_level !== want.tone2_level)
            report_mismatch("tone2_level", 32'(out_data.tone2_level), 32'(want.tone2_level));
          if (out_data.noise_level !== want.noise_level)
            report_mismatch("noise_level", 32'(out_data.noise_level), 32'(want.noise_level));
        end
      end
    end
    samples_due <= expected_samples.size();
  end

endmodule

@@ tb/tb_psg_tone_noise_generator.sv @@
// Drives register writes and time ticks into the generator with random gaps
// on both channels; the checker beside the block predicts and compares.
module tb_psg_tone_noise_generator;
  import psg_pkg::*;

  localparam int TOTAL_ITEMS    = 1650;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 40;
  localparam int TIMEOUT_CYCLES = 1_000_000;

  // Fields of a register byte.
  localparam logic LATCH_MARK   = 1'b1;
  localparam logic DATA_MARK    = 1'b0;
  localparam logic KIND_PERIOD  = 1'b0;
  localparam logic KIND_VOLUME  = 1'b1;
  localparam logic NOISE_PERIOD = 1'b0;
  localparam logic NOISE_WHITE  = 1'b1;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  psg_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  psg_out_t out_data;
  int       error_count;
  int       samples_due;
  bit       calm = 1'b0;
  bit       hold_req = 1'b0;
  int       items_sent = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  psg_tone_noise_generator DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  psg_sample_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .error_count (error_count),
    .samples_due (samples_due)
  );

  // Mostly no gap, sometimes a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] latch_byte(input logic [1:0] ch, input logic kind,
                                            input logic [3:0] nib);
    return {LATCH_MARK, ch, kind, nib};
  endfunction

  function automatic psg_in_t write_item(input logic [7:0] b);
    psg_in_t item;
    item.opcode        = OP_WRITE;
    item.write_byte    = b;
    item.master_cycles = TICK_W'($urandom);
    return item;
  endfunction

  function automatic psg_in_t tick_item(input int cycles);
    psg_in_t item;
    item.opcode        = OP_TICK;
    item.write_byte    = 8'($urandom);
    item.master_cycles = TICK_W'(cycles);
    return item;
  endfunction

  // Offer one item from a falling edge and return at the falling edge after
  // it was accepted.
  task automatic send_item(input psg_in_t item);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = item;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    items_sent++;
  endtask

  // Result side: ready bursts with random stalls, or one long hold-off on request.
  initial begin : receiver
    int burst;
    int gap;
    forever begin
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready = 1'b1;
        burst = calm ? 1 : $urandom_range(1, 20);
        repeat (burst) @(negedge clk);
        gap = pick_gap();
        if (gap > 0) begin
          out_ready = 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    int         r;
    int         n;
    logic [1:0] ch;
    bit         held;
    bit         paused;
    held   = 1'b0;
    paused = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Directed part: reset periods toggle every chip clock, zero and full
    // periods, both volume extremes, every noise rate and both feedback modes,
    // ignored data bytes, and ticks of zero, one and the maximum.
    send_item(tick_item(0));
    repeat (4) send_item(tick_item(PSG_MAX_TICK));
    send_item(write_item(latch_byte(2'd0, KIND_PERIOD, 4'h0)));
    send_item(write_item({DATA_MARK, 7'h00}));
    send_item(write_item(latch_byte(2'd0, KIND_PERIOD, 4'hF)));
    send_item(write_item({DATA_MARK, 7'h7F}));
    send_item(write_item(latch_byte(2'd1, KIND_PERIOD, 4'h5)));
    send_item(write_item({DATA_MARK, 7'h02}));
    send_item(write_item(latch_byte(2'd2, KIND_PERIOD, 4'h3)));
    send_item(write_item({DATA_MARK, 7'h00}));
    send_item(write_item(latch_byte(2'd0, KIND_VOLUME, 4'h0)));
    send_item(write_item(latch_byte(2'd1, KIND_VOLUME, 4'hF)));
    send_item(write_item({DATA_MARK, 7'h15}));
    send_item(write_item(latch_byte(CH_NOISE, KIND_PERIOD, {1'b0, NOISE_PERIOD, RATE_16})));
    send_item(write_item(latch_byte(CH_NOISE, KIND_PERIOD, {1'b1, NOISE_WHITE, RATE_32})));
    send_item(write_item(latch_byte(CH_NOISE, KIND_PERIOD, {1'b0, NOISE_PERIOD, RATE_64})));
    send_item(write_item(latch_byte(CH_NOISE, KIND_PERIOD, {1'b0, NOISE_WHITE, RATE_T2})));
    send_item(write_item({DATA_MARK, 7'h2A}));
    send_item(write_item(latch_byte(CH_NOISE, KIND_VOLUME, 4'hF)));
    repeat (4) send_item(tick_item(PSG_MAX_TICK));
    send_item(tick_item(1));

    // Random part: mostly well-formed programming sequences and tick bursts.
    while (items_sent < TOTAL_ITEMS) begin
      // Hold the result side off while ticks keep coming so the block backs up.
      if (!held && items_sent >= 500) begin
        held     = 1'b1;
        hold_req = 1'b1;
        calm     = 1'b1;
        repeat (40) send_item(tick_item(PSG_MAX_TICK));
      end
      // Pause the sender until every predicted sample has been delivered.
      if (!paused && items_sent >= 1000) begin
        paused   = 1'b1;
        in_valid = 1'b0;
        while (samples_due != 0) @(negedge clk);
      end
      calm = (items_sent >= 1200 && items_sent < 1350);

      r = $urandom_range(0, 99);
      if (r < 30) begin
        // Tone period: latch with the low nibble, usually followed by data.
        ch = 2'($urandom_range(0, 2));
        send_item(write_item(latch_byte(ch, KIND_PERIOD, 4'($urandom))));
        if ($urandom_range(0, 99) < 85) begin
          if ($urandom_range(0, 1) == 0)
            send_item(write_item({DATA_MARK, 1'($urandom), 6'($urandom_range(0, 3))}));
          else
            send_item(write_item({DATA_MARK, 7'($urandom)}));
        end
      end else if (r < 42) begin
        ch = 2'($urandom_range(0, 2));
        send_item(write_item(latch_byte(ch, KIND_VOLUME, 4'($urandom))));
      end else if (r < 50) begin
        send_item(write_item(latch_byte(CH_NOISE, KIND_PERIOD, 4'($urandom))));
      end else if (r < 55) begin
        send_item(write_item(latch_byte(CH_NOISE, KIND_VOLUME, 4'($urandom))));
      end else if (r < 62) begin
        // Any byte at all, including data bytes after the wrong latch.
        send_item(write_item(8'($urandom)));
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          r = $urandom_range(0, 9);
          if (r == 0)
            send_item(tick_item(0));
          else if (r == 1)
            send_item(tick_item(PSG_MAX_TICK));
          else
            send_item(tick_item($urandom_range(1, PSG_MAX_TICK - 1)));
        end
      end
    end
    in_valid = 1'b0;
    calm     = 1'b0;

    while (samples_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    #(8 * TIMEOUT_CYCLES);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+design
design/psg_pkg.sv
design/psg_front.sv
design/psg_back.sv
design/psg_tone_noise_generator.sv
design/psg_checker.sv
tb/psg_sample_checker.sv
tb/tb_psg_tone_noise_generator.sv
